[src/dcc_pkg.sv]
package dcc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgBaseYear     = 2'd0;
  localparam logic [1:0] CfgEpochWeekday = 2'd1;

  localparam logic [13:0] BaseYearReset     = 14'd2000;
  localparam logic [2:0]  EpochWeekdayReset = 3'd6;

  localparam logic [15:0] DaysCommon = 16'd365;
  localparam logic [15:0] DaysLeap   = 16'd366;
  localparam logic [15:0] Cycle400   = 16'd400;
  localparam logic [15:0] Cycle100   = 16'd100;
  localparam logic [15:0] WeekLen    = 16'd7;

  localparam logic [13:0] YearMax   = 14'h3FFF;
  localparam logic [8:0]  Mod400Top = 9'd399;
  localparam logic [6:0]  Mod100Top = 7'd99;
  localparam logic [3:0]  LastMonth = 4'd12;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD400,
    ST_MOD100,
    ST_YEAR,
    ST_MONTH,
    ST_MSUB,
    ST_WDAY,
    ST_FIN
  } dcc_state_e;

  // Shared subtract/compare unit result
  typedef struct packed {
    logic [15:0] diff;
    logic        ge;
  } dcc_alu_res_t;

  // Cumulative days before month idx+1 (idx 0..12)
  function automatic logic [15:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [8:0] v;
    v = 9'd0;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      4'd12:   v = 9'd365;
      default: v = 9'd0;
    endcase
    // leap years gain a day from March on
    if (leap && idx >= 4'd2 && idx <= 4'd12) begin
      v = v + 9'd1;
    end
    return {7'd0, v};
  endfunction

endpackage

[src/dcc_alu.sv]
module dcc_alu
  import dcc_pkg::*;
(
  input  logic [15:0]  op_a_i,
  input  logic [15:0]  op_b_i,
  output dcc_alu_res_t res_o
);

  logic [16:0] full;

  // one subtractor; no borrow means a >= b
  assign full        = {1'b0, op_a_i} - {1'b0, op_b_i};
  assign res_o.diff  = full[15:0];
  assign res_o.ge    = ~full[16];

endmodule

[src/day_count_to_calendar_date.sv]
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    day_count_i
// out      output     out_valid_o / out_stall_i  year_o, month_o, day_of_month_o, weekday_o
// cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// Compares and subtracts share one unit. An item goes through these steps in order: the
// transfer is taken, 400s and then 100s are stripped from the base year for its remainders,
// whole years are stripped from the count, the months are searched in the cumulative-day
// table, the start of the month is subtracted to give the day, the weekday is reduced mod 7
// and the output register is loaded.
// in_stall_o is high while an item is being worked on. A finished result sits in the
// output register; the next item is taken meanwhile and waits in its last step if needed.
// Reset loads base year 2000 and epoch weekday 6 and empties the output register.
module day_count_to_calendar_date
  import dcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [13:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] day_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [13:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [2:0]  weekday_o
);

  dcc_state_e   state_q, state_d;
  logic [13:0]  base_year_q;
  logic [2:0]   epoch_wd_q;
  logic [15:0]  cnt_q, cnt_d;
  logic [15:0]  sum_q, sum_d;
  logic [15:0]  rem_q, rem_d;
  logic [13:0]  y_q, y_d;
  logic [8:0]   r400_q, r400_d;
  logic [6:0]   r100_q, r100_d;
  logic [3:0]   m_q, m_d;
  logic [2:0]   wd_q, wd_d;
  logic         out_valid_q, out_valid_d;
  logic [13:0]  year_q, year_d;
  logic [3:0]   month_q, month_d;
  logic [4:0]   dom_q, dom_d;
  logic [2:0]   wday_q, wday_d;

  logic [15:0]  op_a, op_b;
  dcc_alu_res_t alu;
  logic         leap;
  logic         in_xfer, out_xfer;
  logic [5:0]   wsum_fold1;
  logic [3:0]   wsum_fold2;

  assign in_xfer  = in_valid_i & ~in_stall_o;
  assign out_xfer = out_valid_q & ~out_stall_i;

  // leap from tracked remainders
  assign leap = (r400_q == 9'd0) || ((y_q[1:0] == 2'd0) && (r100_q != 7'd0));

  // eight is one mod seven: the 3-bit digits of the sum keep its remainder
  assign wsum_fold1 = {3'd0, sum_q[2:0]} + {3'd0, sum_q[5:3]} + {3'd0, sum_q[8:6]}
                    + {3'd0, sum_q[11:9]} + {3'd0, sum_q[14:12]} + {5'd0, sum_q[15]};
  assign wsum_fold2 = {1'b0, wsum_fold1[2:0]} + {1'b0, wsum_fold1[5:3]};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_year_q <= BaseYearReset;
      epoch_wd_q  <= EpochWeekdayReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBaseYear:     base_year_q <= cfg_data_i;
        CfgEpochWeekday: epoch_wd_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // shared subtract/compare unit
  dcc_alu u_alu (
    .op_a_i (op_a),
    .op_b_i (op_b),
    .res_o  (alu)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    y_d         = y_q;
    r400_d      = r400_q;
    r100_d      = r100_q;
    m_d         = m_q;
    wd_d        = wd_q;
    year_d      = year_q;
    month_d     = month_q;
    dom_d       = dom_q;
    wday_d      = wday_q;
    out_valid_d = out_valid_q & ~out_xfer;
    op_a        = rem_q;
    op_b        = Cycle400;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cnt_d   = day_count_i;
          sum_d   = day_count_i + {13'd0, epoch_wd_q};
          rem_d   = {2'd0, base_year_q};
          y_d     = base_year_q;
          state_d = ST_MOD400;
        end
      end
      ST_MOD400: begin
        op_b = Cycle400;
        if (alu.ge) begin
          rem_d = alu.diff;
        end else begin
          r400_d  = rem_q[8:0];
          state_d = ST_MOD100;
        end
      end
      ST_MOD100: begin
        op_b = Cycle100;
        if (alu.ge) begin
          rem_d = alu.diff;
        end else begin
          r100_d  = rem_q[6:0];
          rem_d   = cnt_q;
          state_d = ST_YEAR;
        end
      end
      ST_YEAR: begin
        op_b = leap ? DaysLeap : DaysCommon;
        if (alu.ge) begin
          rem_d = alu.diff;
          if (y_q == YearMax) begin
            // year counter wraps to zero
            y_d    = 14'd0;
            r400_d = 9'd0;
            r100_d = 7'd0;
          end else begin
            y_d    = y_q + 14'd1;
            r400_d = (r400_q == Mod400Top) ? 9'd0 : r400_q + 9'd1;
            r100_d = (r100_q == Mod100Top) ? 7'd0 : r100_q + 7'd1;
          end
        end else begin
          m_d     = 4'd1;
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        op_b = cum_days(leap, m_q);
        if (alu.ge && (m_q != LastMonth)) begin
          m_d = m_q + 4'd1;
        end else begin
          state_d = ST_MSUB;
        end
      end
      ST_MSUB: begin
        op_b    = cum_days(leap, m_q - 4'd1);
        rem_d   = alu.diff;
        state_d = ST_WDAY;
      end
      ST_WDAY: begin
        // folded sum is at most 11: one conditional subtract of 7 finishes it
        op_a    = {12'd0, wsum_fold2};
        op_b    = WeekLen;
        wd_d    = alu.ge ? alu.diff[2:0] : wsum_fold2[2:0];
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          year_d      = y_q;
          month_d     = m_q;
          dom_d       = rem_q[4:0] + 5'd1;
          wday_d      = ((wd_q == 3'd0) && (sum_q != 16'd0)) ? 3'd7 : wd_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    sum_q   <= sum_d;
    rem_q   <= rem_d;
    y_q     <= y_d;
    r400_q  <= r400_d;
    r100_q  <= r100_d;
    m_q     <= m_d;
    wd_q    <= wd_d;
    year_q  <= year_d;
    month_q <= month_d;
    dom_q   <= dom_d;
    wday_q  <= wday_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign year_o         = year_q;
  assign month_o        = month_q;
  assign day_of_month_o = dom_q;
  assign weekday_o      = wday_q;

  // checks
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o >= 4'd1) && (month_o <= LastMonth))
    else $error("month out of range");

  a_rem_in_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MONTH) |-> (rem_q < DaysLeap))
    else $error("day remainder exceeds a year");

  a_start_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_MOD400))
    else $error("accepted item did not start conversion");

endmodule

[sim/calendar_date_checker.sv]
`timescale 1ns / 100ps

// Watches the day-count and calendar-date channels, predicts each date and
// compares it with what the block delivers.
module calendar_date_checker
  import dcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [13:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [15:0] day_count_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [13:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_of_month_i,
  input  logic [2:0]  weekday_i,
  input  logic        end_of_run_i,
  output int          pending_o,
  output int          fail_count_o
);

  typedef struct packed {
    logic [15:0] day_count;  // kept for messages only
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [2:0]  wday;
  } cal_date_t;

  logic [13:0] base_year_q;
  logic [2:0]  epoch_wday_q;
  cal_date_t   dates_due[$];
  int          mismatches = 0;
  bit          leftovers_done = 1'b0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] calendar check: %s", $time, msg);
  endtask

  function automatic logic leap_year(input logic [13:0] yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // days in the months before month_idx+1
  function automatic int days_before(input logic leap, input int month_idx);
    int d;
    case (month_idx)
      0:       d = 0;
      1:       d = 31;
      2:       d = 59;
      3:       d = 90;
      4:       d = 120;
      5:       d = 151;
      6:       d = 181;
      7:       d = 212;
      8:       d = 243;
      9:       d = 273;
      10:      d = 304;
      11:      d = 334;
      default: d = 365;
    endcase
    if (leap && month_idx >= 2) begin
      d++;
    end
    return d;
  endfunction

  function automatic cal_date_t calendar_of(input logic [15:0] count,
                                            input logic [13:0] base,
                                            input logic [2:0]  wday_off);
    cal_date_t   d;
    logic [13:0] yr;
    int          left;
    int          m;
    logic [15:0] wsum;
    yr   = base;
    left = int'(count);
    // strip whole years; the year counter wraps at 14 bits
    while (left >= (leap_year(yr) ? 366 : 365)) begin
      left -= leap_year(yr) ? 366 : 365;
      yr = yr + 14'd1;
    end
    // month search in the table of the final year
    m = 1;
    while (m < 12 && left >= days_before(leap_year(yr), m)) begin
      m++;
    end
    left -= days_before(leap_year(yr), m - 1);
    // weekday: 16-bit wrapping sum, small sums pass through, zero remainder is 7
    wsum = count + {13'd0, wday_off};
    d.day_count = count;
    d.year      = yr;
    d.month     = m[3:0];
    d.mday      = left[4:0] + 5'd1;
    if (wsum < 16'd7) begin
      d.wday = wsum[2:0];
    end else begin
      d.wday = 3'(wsum % 16'd7);
      if (d.wday == 3'd0) begin
        d.wday = 3'd7;
      end
    end
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cal_date_t want;
    if (!rst_ni) begin
      base_year_q  <= BaseYearReset;
      epoch_wday_q <= EpochWeekdayReset;
      dates_due.delete();
      pending_o    <= 0;
    end else begin
      // register writes; unknown indexes leave the settings alone
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgBaseYear:     base_year_q  <= cfg_data_i;
          CfgEpochWeekday: epoch_wday_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      // result transfer against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (dates_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d-%0d-%0d wd %0d",
                                    year_i, month_i, day_of_month_i, weekday_i));
        end else begin
          want = dates_due.pop_front();
          if (year_i !== want.year) begin
            report_mismatch($sformatf("count %0d: year %0d, want %0d",
                                      want.day_count, year_i, want.year));
          end
          if (month_i !== want.month) begin
            report_mismatch($sformatf("count %0d: month %0d, want %0d",
                                      want.day_count, month_i, want.month));
          end
          if (day_of_month_i !== want.mday) begin
            report_mismatch($sformatf("count %0d: day %0d, want %0d",
                                      want.day_count, day_of_month_i, want.mday));
          end
          if (weekday_i !== want.wday) begin
            report_mismatch($sformatf("count %0d: weekday %0d, want %0d",
                                      want.day_count, weekday_i, want.wday));
          end
        end
      end
      // input transfer
      if (in_valid_i && !in_stall_i) begin
        dates_due.push_back(calendar_of(day_count_i, base_year_q, epoch_wday_q));
      end
      // anything still owed at the end is a miss
      if (end_of_run_i && !leftovers_done) begin
        leftovers_done = 1'b1;
        foreach (dates_due[k]) begin
          report_mismatch($sformatf("no result for count %0d", dates_due[k].day_count));
        end
      end
      pending_o <= dates_due.size();
    end
  end

endmodule

[sim/day_count_to_calendar_date_tb.sv]
`timescale 1ns / 100ps

module day_count_to_calendar_date_tb;
  import dcc_pkg::*;

  // indexes that decode to no register
  localparam logic [1:0] CfgSpareA = 2'd2;
  localparam logic [1:0] CfgSpareB = 2'd3;

  localparam int NumPhases     = 9;
  localparam int ItemsPerPhase = 78;
  localparam int SettleCycles  = 300;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [13:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] day_count;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [2:0]  weekday;
  logic        end_of_run;
  int          dates_pending;
  int          fail_count;
  int          send_idle_pct = 15;
  int          recv_stall_pct = 48;

  day_count_to_calendar_date u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .day_count_i    (day_count),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .year_o         (year),
    .month_o        (month),
    .day_of_month_o (day_of_month),
    .weekday_o      (weekday)
  );

  calendar_date_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .day_count_i    (day_count),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .year_i         (year),
    .month_i        (month),
    .day_of_month_i (day_of_month),
    .weekday_i      (weekday),
    .end_of_run_i   (end_of_run),
    .pending_o      (dates_pending),
    .fail_count_o   (fail_count)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // hard stop
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // one day-count transfer, with random idle cycles ahead of it
  task automatic send_day(input logic [15:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    day_count <= count;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait until every date has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (dates_pending != 0) @(posedge clk);
  endtask

  // program both registers; optionally poke the undecoded indexes too
  task automatic apply_setting(input logic [13:0] base, input logic [2:0] wday,
                               input bit spare);
    logic [10:0] junk;
    junk     = 11'($urandom);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgBaseYear;
    cfg_data <= base;
    @(posedge clk);
    cfg_idx  <= CfgEpochWeekday;
    cfg_data <= {junk, wday};
    @(posedge clk);
    if (spare) begin
      cfg_idx  <= CfgSpareA;
      cfg_data <= 14'h3FFF;
      @(posedge clk);
      cfg_idx  <= CfgSpareB;
      cfg_data <= 14'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // uniform in three cases of eight, else weighted to the ends of the range and the first few years
  function automatic logic [15:0] pick_day_count();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(6));
      3:       return 16'hFFFF - 16'($urandom_range(6));
      4:       return 16'($urandom_range(1500));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [15:0] corner_days[$];
    logic [13:0] phase_base[NumPhases];
    logic [2:0]  phase_wday[NumPhases];

    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= CfgBaseYear;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    day_count  <= '0;
    end_of_run <= 1'b0;

    // Feb 28/29 and Mar 1 in leap and common years, year ends, the skipped
    // leap day of 2100, weekday sums of 7 and one that wraps to zero
    corner_days = '{16'd0, 16'd1, 16'd31, 16'd58, 16'd59, 16'd60, 16'd335, 16'd365,
                    16'd366, 16'd424, 16'd425, 16'd36583, 16'd36584, 16'd32768,
                    16'd21845, 16'd43690, 16'd65529, 16'd65530, 16'd65535};

    // base years 1 and 9820, year zero, settings that make the year wrap,
    // the out-of-range weekday offset, then two random settings
    phase_base = '{BaseYearReset, 14'd1, 14'd9820, 14'd0, 14'd16383, 14'd16250,
                   14'd1900, 14'd1 + 14'($urandom_range(9819)), 14'($urandom)};
    phase_wday = '{EpochWeekdayReset, 3'd0, 3'd6, 3'd7, 3'd3, 3'd5, 3'd1,
                   3'($urandom_range(6)), 3'($urandom)};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < NumPhases; p++) begin
      // first phase runs on reset values
      if (p > 0) begin
        drain_results();
        apply_setting(phase_base[p], phase_wday[p], (p == 2) || (p == 5));
      end
      if (p < 3) begin
        send_idle_pct  = 15;
        recv_stall_pct <= 48;
      end else if (p < 6) begin
        send_idle_pct  = 48;
        recv_stall_pct <= 15;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
      end
      if (p == 0) begin
        foreach (corner_days[k]) begin
          send_day(corner_days[k]);
        end
      end
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // let the block run dry once mid-stream
        if (p == 1 && n == ItemsPerPhase / 2) begin
          drain_results();
        end
        send_day(pick_day_count());
      end
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    end_of_run <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
